### rtl/mmc_sysex_packet_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// mmc_sysex_packet_parser_unit assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef MMC_SYSEX_PACKET_PARSER_UNIT_MACROS_SVH
`define MMC_SYSEX_PACKET_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define MSPU_AST_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSPU_AST_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mspu_pkg.sv
// ----------------------------------------------------------------------------
// mspu_pkg
// Types and constants of the machine control SysEx7 packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mspu_pkg;

	// packet status codes
	localparam logic [3:0] ST_COMPLETE = 4'd0;
	localparam logic [3:0] ST_START    = 4'd1;
	localparam logic [3:0] ST_CONT     = 4'd2;
	localparam logic [3:0] ST_END      = 4'd3;

	localparam logic [7:0] MMC_ID    = 8'h7F;
	localparam logic [7:0] MMC_SUBID = 8'h06;

	typedef struct packed {
		logic        is_sysex;
		logic [31:0] word0;
		logic [31:0] word1;
		logic        has_word1;
	} pkt_t;

	typedef struct packed {
		logic [7:0] device_id;
		logic [7:0] command_code;
		logic [7:0] data_byte;
		logic       has_data;
		logic       last;
		logic       overflow;
	} res_t;

	typedef struct packed {
		logic cap;
		logic clr;
		logic app;
		logic emit_init;
		logic emit_run;
		logic out_fast;
		logic out_hdr;
	} ctl_cmd_t;

	typedef struct packed {
		logic       sysex;
		logic [3:0] status;
		logic       fast_hit;
		logic       app_done;
		logic       hdr_ok;
		logic       fill_eq4;
		logic       out_free;
		logic       emit_done;
	} dp_stat_t;

endpackage

`default_nettype wire

### rtl/mspu_dpath.sv
// ----------------------------------------------------------------------------
// mspu_dpath
// Packet register, message buffer, header bytes, emit pointer and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module mspu_dpath import mspu_pkg::*; #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  pkt_t     pkt,
	input  ctl_cmd_t cmd,
	output dp_stat_t st,
	input  logic     res_stall,
	output logic     res_valid,
	output res_t     res
);

	localparam int FW = $clog2(BUFFER_BYTES + 1);
	localparam int AW = $clog2(BUFFER_BYTES);
	localparam logic [FW-1:0] FILL_MAX = FW'(BUFFER_BYTES);
	localparam logic [FW-1:0] FILL_HDR = FW'(4);

	pkt_t          pkt_q;
	logic [7:0]    mem_q [BUFFER_BYTES];
	logic [7:0]    hdr_q [4];
	logic [7:0]    rd_data_q;
	logic [FW-1:0] fill_q;
	logic          ovf_q;
	logic [2:0]    k_q;
	logic [FW-1:0] ptr_q;
	logic          dvalid_q;
	logic          out_valid_q;
	res_t          out_q;

	logic [3:0]    cnt;
	logic [2:0]    cnt6;
	logic [2:0]    nbytes;
	logic [7:0]    app_byte;
	logic          out_free;
	logic          rd_en;
	logic          emit_load;
	logic          emit_last;

	always_comb begin
		cnt    = pkt_q.word0[19:16];
		cnt6   = (cnt > 4'd6) ? 3'd6 : cnt[2:0];
		nbytes = pkt_q.has_word1 ? cnt6 : ((cnt6 > 3'd2) ? 3'd2 : cnt6);
		case (k_q)
			3'd0:    app_byte = pkt_q.word0[15:8];
			3'd1:    app_byte = pkt_q.word0[7:0];
			3'd2:    app_byte = pkt_q.word1[31:24];
			3'd3:    app_byte = pkt_q.word1[23:16];
			3'd4:    app_byte = pkt_q.word1[15:8];
			default: app_byte = pkt_q.word1[7:0];
		endcase
	end

	assign out_free  = !out_valid_q || !res_stall;
	assign emit_load = cmd.emit_run && dvalid_q && out_free;
	assign emit_last = (ptr_q == fill_q);
	assign rd_en     = cmd.emit_run && (!dvalid_q || emit_load) && (ptr_q < fill_q);

	always_comb begin
		st.sysex     = pkt_q.is_sysex;
		st.status    = pkt_q.word0[23:20];
		st.fast_hit  = (cnt >= 4'd4) && (pkt_q.word0[15:8] == MMC_ID) &&
			pkt_q.has_word1 && (pkt_q.word1[31:24] == MMC_SUBID);
		st.app_done  = (k_q == nbytes);
		st.hdr_ok    = (fill_q >= FILL_HDR) && (hdr_q[0] == MMC_ID) &&
			(hdr_q[2] == MMC_SUBID);
		st.fill_eq4  = (fill_q == FILL_HDR);
		st.out_free  = out_free;
		st.emit_done = emit_load && emit_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			pkt_q <= pkt;
		end
	end

	// buffer write (append) and read (emit)
	always_ff @(posedge clk) begin
		if (cmd.app && !st.app_done && (fill_q < FILL_MAX)) begin
			mem_q[fill_q[AW-1:0]] <= app_byte;
			if (fill_q < FILL_HDR) begin
				hdr_q[fill_q[1:0]] <= app_byte;
			end
		end
		if (rd_en) begin
			rd_data_q <= mem_q[ptr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			ovf_q    <= 1'b0;
			k_q      <= '0;
			ptr_q    <= '0;
			dvalid_q <= 1'b0;
		end else begin
			if (cmd.cap) begin
				k_q <= '0;
			end
			if (cmd.clr) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else if (cmd.app && !st.app_done) begin
				k_q <= k_q + 3'd1;
				if (fill_q < FILL_MAX) begin
					fill_q <= fill_q + FW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.emit_init) begin
				ptr_q    <= FILL_HDR;
				dvalid_q <= 1'b0;
			end else if (rd_en) begin
				ptr_q    <= ptr_q + FW'(1);
				dvalid_q <= 1'b1;
			end else if (emit_load) begin
				dvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_fast || cmd.out_hdr || emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_fast) begin
			out_q <= '{device_id: pkt_q.word0[7:0], command_code: pkt_q.word1[23:16],
				data_byte: 8'h00, has_data: 1'b0, last: 1'b1, overflow: 1'b0};
		end else if (cmd.out_hdr) begin
			out_q <= '{device_id: hdr_q[1], command_code: hdr_q[3],
				data_byte: 8'h00, has_data: 1'b0, last: 1'b1, overflow: ovf_q};
		end else if (emit_load) begin
			out_q <= '{device_id: hdr_q[1], command_code: hdr_q[3],
				data_byte: rd_data_q, has_data: 1'b1, last: emit_last, overflow: ovf_q};
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

`default_nettype wire

### rtl/mspu_ctrl.sv
// ----------------------------------------------------------------------------
// mspu_ctrl
// Sequencer: decode, byte append, message check and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module mspu_ctrl import mspu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pkt_valid,
	output logic     pkt_stall,
	input  dp_stat_t st,
	output ctl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PARSE  = 3'd1;
	localparam logic [2:0] S_APPEND = 3'd2;
	localparam logic [2:0] S_CHECK  = 3'd3;
	localparam logic [2:0] S_FAST   = 3'd4;
	localparam logic [2:0] S_HDR    = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign pkt_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (pkt_valid) begin
					cmd.cap = 1'b1;
					state_d = S_PARSE;
				end
			end
			S_PARSE: begin
				state_d = S_IDLE;
				if (st.sysex) begin
					case (st.status) inside
						ST_COMPLETE: begin
							if (st.fast_hit) begin
								state_d = S_FAST;
							end
						end
						ST_START: begin
							cmd.clr = 1'b1;
							state_d = S_APPEND;
						end
						ST_CONT, ST_END: begin
							state_d = S_APPEND;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_APPEND: begin
				if (st.app_done) begin
					state_d = (st.status == ST_END) ? S_CHECK : S_IDLE;
				end else begin
					cmd.app = 1'b1;
				end
			end
			S_CHECK: begin
				if (!st.hdr_ok) begin
					cmd.clr = 1'b1;
					state_d = S_IDLE;
				end else if (st.fill_eq4) begin
					state_d = S_HDR;
				end else begin
					cmd.emit_init = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_FAST: begin
				if (st.out_free) begin
					cmd.out_fast = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_HDR: begin
				if (st.out_free) begin
					cmd.out_hdr = 1'b1;
					cmd.clr     = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_EMIT: begin
				cmd.emit_run = 1'b1;
				if (st.emit_done) begin
					cmd.clr = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/mmc_sysex_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// mmc_sysex_packet_parser_unit
// Machine control recognizer over 64-bit SysEx7 packets.
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+---------------
//   packet   | pkt_valid  | pkt_stall  | pkt  (pkt_t)
//   result   | res_valid  | res_stall  | res  (res_t)
//
// One packet at a time: accept, decode, then for a start, continue or end packet
// one packet byte (0..6) per cycle into the single-port buffer and an exit step;
// for an end packet a check, a buffer read and one emitted result per cycle while
// results are not stalled (up to BUFFER_BYTES-4 results, or one header-only result).
// Reset clears the controller, fill count and overflow flag; no buffer sweep.
// A stalled header-only result holds in the output register while the next packet
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc_sysex_packet_parser_unit import mspu_pkg::*; #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pkt_valid,
	output logic pkt_stall,
	input  pkt_t pkt,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	ctl_cmd_t cmd;
	dp_stat_t st;

	mspu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.st        (st),
		.cmd       (cmd)
	);

	mspu_dpath #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.cmd       (cmd),
		.st        (st),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

`default_nettype wire

### rtl/mspu_checker.sv
// ----------------------------------------------------------------------------
// mspu_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mmc_sysex_packet_parser_unit_macros.svh"

module mspu_checker import mspu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pkt_valid,
	input logic pkt_stall,
	input pkt_t pkt,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	`MSPU_AST_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")
	`MSPU_AST_NEXT(a_pkt_hold, clk, arst_n, pkt_valid && pkt_stall, pkt_valid && $stable(pkt), "stalled packet changed")
	`MSPU_AST_SAME(a_nodata_last, clk, arst_n, res_valid && !res.has_data, res.last, "result without data is not last")
	`MSPU_AST_SAME(a_nodata_zero, clk, arst_n, res_valid && !res.has_data, res.data_byte == 8'h00, "data byte set without data")
	`MSPU_AST_NEXT(a_one_pkt, clk, arst_n, pkt_valid && !pkt_stall, pkt_stall, "packet taken while previous in work")

endmodule

bind mmc_sysex_packet_parser_unit mspu_checker u_mspu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pkt_valid (pkt_valid),
	.pkt_stall (pkt_stall),
	.pkt       (pkt),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

`default_nettype wire
